FILE: rtl/qvf_pkg.sv
package qvf_pkg;

  // core sizing
  localparam int COUNT_BITS     = 32;
  localparam int COEF_FRAC_BITS = 22;

  // fixed field widths
  localparam int COEF_W  = 24;
  localparam int SCALE_W = 16;
  localparam int RATE_W  = 32;
  localparam int TIME_W  = 32;
  localparam int POS_W   = 32;

  // rate path: magnitude is capped, product feeds a restoring divider
  localparam int MAG_CAP_BITS = 48;
  localparam int MAG_W        = (COUNT_BITS > MAG_CAP_BITS) ? MAG_CAP_BITS : COUNT_BITS;
  localparam int PROD_W       = MAG_W + SCALE_W;
  localparam int RATE_FRAC    = 16;
  localparam int QUO_W        = RATE_W - 1;
  localparam int SAT_SHIFT    = QUO_W - RATE_FRAC;
  localparam int CMP_W        = (PROD_W > TIME_W + SAT_SHIFT) ? PROD_W : TIME_W + SAT_SHIFT;
  localparam int STEP_W       = $clog2(QUO_W);

  // filter path
  localparam int FMUL_W = COEF_W + RATE_W;
  localparam int ACC_W  = FMUL_W + 3;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

  localparam logic signed [RATE_W-1:0] RATE_MAX = 32'sh7FFFFFFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN = 32'sh80000000;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FB_COEF_1  = 3'd0,
    REG_FB_COEF_2  = 3'd1,
    REG_FF_COEF_0  = 3'd2,
    REG_FF_COEF_1  = 3'd3,
    REG_FF_COEF_2  = 3'd4,
    REG_RATE_SCALE = 3'd5
  } reg_e;

  localparam logic signed [COEF_W-1:0] FB_COEF_1_RST  = 24'sd8016154;
  localparam logic signed [COEF_W-1:0] FB_COEF_2_RST  = -24'sd3837788;
  localparam logic signed [COEF_W-1:0] FF_COEF_0_RST  = 24'sd3775;
  localparam logic signed [COEF_W-1:0] FF_COEF_1_RST  = 24'sd7969;
  localparam logic signed [COEF_W-1:0] FF_COEF_2_RST  = 24'sd3775;
  localparam logic        [SCALE_W-1:0] RATE_SCALE_RST = 16'd15;

  typedef struct packed {
    logic signed [COEF_W-1:0] fb_coef_1;
    logic signed [COEF_W-1:0] fb_coef_2;
    logic signed [COEF_W-1:0] ff_coef_0;
    logic signed [COEF_W-1:0] ff_coef_1;
    logic signed [COEF_W-1:0] ff_coef_2;
    logic        [SCALE_W-1:0] rate_scale;
  } cfg_t;

  typedef enum logic [2:0] {
    TAP_X,
    TAP_H1,
    TAP_H2,
    TAP_F1,
    TAP_F2
  } tap_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SAMPLE,
    S_PREP,
    S_RATE_MUL,
    S_RATE_CHK,
    S_RATE_DIV,
    S_RATE_SIGN,
    S_FILT_MUL,
    S_FILT_ACC,
    S_FILT_END,
    S_DONE
  } state_e;

  typedef struct packed {
    logic latch;
    logic sample;
    logic prep;
    logic rate_mul;
    logic rate_chk;
    logic div_step;
    logic rate_sign;
    logic mul_en;
    tap_e tap;
    logic acc_clr;
    logic acc_add;
    logic filt_done;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic div_start;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/qvf_if.sv
interface qvf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic                        line_a;
  logic                        line_b;
  logic [qvf_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, operation, line_a, line_b, now_ms, input ready);
  modport sink   (input valid, operation, line_a, line_b, now_ms, output ready);
endinterface

interface qvf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qvf_pkg::POS_W-1:0]   position_count;
  logic signed [qvf_pkg::RATE_W-1:0]  raw_rate;
  logic signed [qvf_pkg::RATE_W-1:0]  filtered_rate;

  modport source (output valid, position_count, raw_rate, filtered_rate, input ready);
  modport sink   (input valid, position_count, raw_rate, filtered_rate, output ready);
endinterface

FILE: rtl/qvf_regs.sv
module qvf_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qvf_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [qvf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [qvf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output qvf_pkg::cfg_t                      cfg_o
);

  qvf_pkg::cfg_t cfg_q;
  qvf_pkg::reg_e idx;
  logic          wr_en;

  assign pready = 1'b1;
  assign idx    = qvf_pkg::reg_e'(paddr[qvf_pkg::APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb_coef_1  <= qvf_pkg::FB_COEF_1_RST;
      cfg_q.fb_coef_2  <= qvf_pkg::FB_COEF_2_RST;
      cfg_q.ff_coef_0  <= qvf_pkg::FF_COEF_0_RST;
      cfg_q.ff_coef_1  <= qvf_pkg::FF_COEF_1_RST;
      cfg_q.ff_coef_2  <= qvf_pkg::FF_COEF_2_RST;
      cfg_q.rate_scale <= qvf_pkg::RATE_SCALE_RST;
    end else if (wr_en) begin
      case (idx)
        qvf_pkg::REG_FB_COEF_1:  cfg_q.fb_coef_1  <= pwdata[qvf_pkg::COEF_W-1:0];
        qvf_pkg::REG_FB_COEF_2:  cfg_q.fb_coef_2  <= pwdata[qvf_pkg::COEF_W-1:0];
        qvf_pkg::REG_FF_COEF_0:  cfg_q.ff_coef_0  <= pwdata[qvf_pkg::COEF_W-1:0];
        qvf_pkg::REG_FF_COEF_1:  cfg_q.ff_coef_1  <= pwdata[qvf_pkg::COEF_W-1:0];
        qvf_pkg::REG_FF_COEF_2:  cfg_q.ff_coef_2  <= pwdata[qvf_pkg::COEF_W-1:0];
        qvf_pkg::REG_RATE_SCALE: cfg_q.rate_scale <= pwdata[qvf_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficients read back sign extended
  always_comb begin
    case (idx)
      qvf_pkg::REG_FB_COEF_1:  prdata = qvf_pkg::APB_DATA_W'(cfg_q.fb_coef_1);
      qvf_pkg::REG_FB_COEF_2:  prdata = qvf_pkg::APB_DATA_W'(cfg_q.fb_coef_2);
      qvf_pkg::REG_FF_COEF_0:  prdata = qvf_pkg::APB_DATA_W'(cfg_q.ff_coef_0);
      qvf_pkg::REG_FF_COEF_1:  prdata = qvf_pkg::APB_DATA_W'(cfg_q.ff_coef_1);
      qvf_pkg::REG_FF_COEF_2:  prdata = qvf_pkg::APB_DATA_W'(cfg_q.ff_coef_2);
      qvf_pkg::REG_RATE_SCALE: prdata = qvf_pkg::APB_DATA_W'(cfg_q.rate_scale);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/qvf_ctrl.sv
module qvf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_update_i,
  input  qvf_pkg::status_t  sts_i,
  output logic              in_ready_o,
  output qvf_pkg::cmd_t     cmd_o
);

  qvf_pkg::state_e             state_q, state_d;
  qvf_pkg::tap_e               tap_q, tap_d;
  logic [qvf_pkg::STEP_W-1:0]  step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qvf_pkg::S_IDLE;
      tap_q   <= qvf_pkg::TAP_X;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      step_q  <= step_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    tap_d   = qvf_pkg::TAP_X;
    step_d  = '0;
    case (state_q)
      qvf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = in_update_i ? qvf_pkg::S_PREP : qvf_pkg::S_SAMPLE;
        end
      end
      qvf_pkg::S_SAMPLE:   state_d = qvf_pkg::S_DONE;
      qvf_pkg::S_PREP:     state_d = sts_i.go ? qvf_pkg::S_RATE_MUL : qvf_pkg::S_FILT_MUL;
      qvf_pkg::S_RATE_MUL: state_d = qvf_pkg::S_RATE_CHK;
      qvf_pkg::S_RATE_CHK: begin
        state_d = sts_i.div_start ? qvf_pkg::S_RATE_DIV : qvf_pkg::S_FILT_MUL;
      end
      qvf_pkg::S_RATE_DIV: begin
        if (step_q == qvf_pkg::STEP_W'(qvf_pkg::QUO_W - 1)) begin
          state_d = qvf_pkg::S_RATE_SIGN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      qvf_pkg::S_RATE_SIGN: state_d = qvf_pkg::S_FILT_MUL;
      qvf_pkg::S_FILT_MUL: begin
        case (tap_q)
          qvf_pkg::TAP_X:  tap_d = qvf_pkg::TAP_H1;
          qvf_pkg::TAP_H1: tap_d = qvf_pkg::TAP_H2;
          qvf_pkg::TAP_H2: tap_d = qvf_pkg::TAP_F1;
          qvf_pkg::TAP_F1: tap_d = qvf_pkg::TAP_F2;
          default:         state_d = qvf_pkg::S_FILT_ACC;
        endcase
      end
      qvf_pkg::S_FILT_ACC: state_d = qvf_pkg::S_FILT_END;
      qvf_pkg::S_FILT_END: state_d = qvf_pkg::S_DONE;
      qvf_pkg::S_DONE: begin
        if (!sts_i.out_busy) begin
          state_d = qvf_pkg::S_IDLE;
        end
      end
      default: state_d = qvf_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      qvf_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
      end
      qvf_pkg::S_SAMPLE:    cmd_o.sample    = 1'b1;
      qvf_pkg::S_PREP:      cmd_o.prep      = 1'b1;
      qvf_pkg::S_RATE_MUL:  cmd_o.rate_mul  = 1'b1;
      qvf_pkg::S_RATE_CHK:  cmd_o.rate_chk  = 1'b1;
      qvf_pkg::S_RATE_DIV:  cmd_o.div_step  = 1'b1;
      qvf_pkg::S_RATE_SIGN: cmd_o.rate_sign = 1'b1;
      qvf_pkg::S_FILT_MUL: begin
        // product of the previous tap is summed while the next one multiplies
        cmd_o.mul_en  = 1'b1;
        cmd_o.tap     = tap_q;
        cmd_o.acc_clr = (tap_q == qvf_pkg::TAP_X);
        cmd_o.acc_add = (tap_q != qvf_pkg::TAP_X);
      end
      qvf_pkg::S_FILT_ACC:  cmd_o.acc_add   = 1'b1;
      qvf_pkg::S_FILT_END:  cmd_o.filt_done = 1'b1;
      qvf_pkg::S_DONE:      cmd_o.out_load  = !sts_i.out_busy;
      default: ;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != qvf_pkg::S_IDLE)
    else $error("accepted item did not start processing");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy)
    else $error("result loaded over a pending result");

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == qvf_pkg::S_RATE_DIV |-> step_q < qvf_pkg::STEP_W'(qvf_pkg::QUO_W))
    else $error("divider step count out of range");

  a_all_taps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == qvf_pkg::S_FILT_ACC |->
      $past(state_q) == qvf_pkg::S_FILT_MUL && $past(tap_q) == qvf_pkg::TAP_F2)
    else $error("filter sum closed before the last tap");

endmodule

FILE: rtl/qvf_dp.sv
module qvf_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  qvf_pkg::cfg_t                      cfg_i,
  input  qvf_pkg::cmd_t                      cmd_i,
  input  logic                               in_line_a_i,
  input  logic                               in_line_b_i,
  input  logic [qvf_pkg::TIME_W-1:0]         in_now_ms_i,
  input  logic                               out_ready_i,
  output qvf_pkg::status_t                   sts_o,
  output logic                               out_valid_o,
  output logic signed [qvf_pkg::POS_W-1:0]   out_position_count_o,
  output logic signed [qvf_pkg::RATE_W-1:0]  out_raw_rate_o,
  output logic signed [qvf_pkg::RATE_W-1:0]  out_filtered_rate_o
);

  localparam int CB = qvf_pkg::COUNT_BITS;

  // transition codes {previous a b, new a b}
  localparam logic [3:0] CODE_UP_0 = 4'b1101;
  localparam logic [3:0] CODE_UP_1 = 4'b0100;
  localparam logic [3:0] CODE_UP_2 = 4'b0010;
  localparam logic [3:0] CODE_UP_3 = 4'b1011;
  localparam logic [3:0] CODE_DN_0 = 4'b1110;
  localparam logic [3:0] CODE_DN_1 = 4'b0111;
  localparam logic [3:0] CODE_DN_2 = 4'b0001;
  localparam logic [3:0] CODE_DN_3 = 4'b1000;

  function automatic logic [CB-1:0] cnt_mag(input logic [CB-1:0] v);
    return v[CB-1] ? (~v + 1'b1) : v;
  endfunction

  // latched item
  logic                        line_a_q, line_b_q;
  logic [qvf_pkg::TIME_W-1:0]  now_q;

  // block state
  logic [1:0]                        prev_lines_q;
  logic [CB-1:0]                     count_q, clast_q;
  logic [qvf_pkg::TIME_W-1:0]        tlast_q;
  logic signed [qvf_pkg::RATE_W-1:0] raw_now_q, raw_h1_q, raw_h2_q, filt_h1_q, filt_h2_q;

  // working registers
  logic [qvf_pkg::TIME_W-1:0]        dt_q, rem_q;
  logic [CB-1:0]                     dm_q;
  logic                              neg_q, big_q;
  logic [qvf_pkg::PROD_W-1:0]        p_q;
  logic [qvf_pkg::QUO_W-1:0]         dq_q;
  logic signed [qvf_pkg::FMUL_W-1:0] prod_q;
  logic signed [qvf_pkg::ACC_W-1:0]  acc_q;

  // output register
  logic                              out_valid_q;
  logic signed [qvf_pkg::POS_W-1:0]  out_pos_q;
  logic signed [qvf_pkg::RATE_W-1:0] out_raw_q, out_filt_q;

  logic [3:0]                        code;
  logic [qvf_pkg::TIME_W-1:0]        dt_d;
  logic [CB-1:0]                     diff;
  logic                              sat, scale_zero;
  logic [qvf_pkg::TIME_W:0]          trial, trial_sub;
  logic                              fits;
  logic [qvf_pkg::RATE_W-1:0]        quo_ext;
  logic signed [qvf_pkg::COEF_W-1:0] tap_coef;
  logic signed [qvf_pkg::RATE_W-1:0] tap_data;
  logic signed [qvf_pkg::FMUL_W-1:0] prod_d;
  logic signed [qvf_pkg::ACC_W-1:0]  acc_rnd, filt_sh;
  logic [qvf_pkg::ACC_W-qvf_pkg::RATE_W:0] filt_hi;
  logic signed [qvf_pkg::RATE_W-1:0] filt_y;

  assign code = {prev_lines_q, line_a_q, line_b_q};

  // velocity update set-up
  assign dt_d   = now_q - tlast_q;
  assign diff   = count_q - clast_q;
  assign sts_o.go = (cnt_mag(count_q) > cnt_mag(clast_q)) && (dt_d != '0);

  assign scale_zero = (cfg_i.rate_scale == '0);
  assign sat = big_q ||
               (qvf_pkg::CMP_W'(p_q) >= (qvf_pkg::CMP_W'(dt_q) << qvf_pkg::SAT_SHIFT));
  assign sts_o.div_start = !scale_zero && !sat;

  // one restoring divide step
  assign trial     = {rem_q, dq_q[qvf_pkg::QUO_W-1]};
  assign fits      = (trial >= {1'b0, dt_q});
  assign trial_sub = trial - {1'b0, dt_q};
  assign quo_ext   = {1'b0, dq_q};

  always_comb begin
    case (cmd_i.tap)
      qvf_pkg::TAP_X: begin
        tap_coef = cfg_i.ff_coef_0;
        tap_data = raw_now_q;
      end
      qvf_pkg::TAP_H1: begin
        tap_coef = cfg_i.ff_coef_1;
        tap_data = raw_h1_q;
      end
      qvf_pkg::TAP_H2: begin
        tap_coef = cfg_i.ff_coef_2;
        tap_data = raw_h2_q;
      end
      qvf_pkg::TAP_F1: begin
        tap_coef = cfg_i.fb_coef_1;
        tap_data = filt_h1_q;
      end
      default: begin
        tap_coef = cfg_i.fb_coef_2;
        tap_data = filt_h2_q;
      end
    endcase
  end

  assign prod_d = tap_coef * tap_data;

  // round half up, floor shift, saturate
  assign acc_rnd = acc_q + qvf_pkg::RND_HALF;
  assign filt_sh = acc_rnd >>> qvf_pkg::COEF_FRAC_BITS;
  assign filt_hi = filt_sh[qvf_pkg::ACC_W-1:qvf_pkg::RATE_W-1];
  assign filt_y  = ((&filt_hi) || !(|filt_hi)) ? filt_sh[qvf_pkg::RATE_W-1:0] :
                   (filt_sh[qvf_pkg::ACC_W-1] ? qvf_pkg::RATE_MIN : qvf_pkg::RATE_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_lines_q <= '0;
      count_q      <= '0;
      clast_q      <= '0;
      tlast_q      <= '0;
      raw_now_q    <= '0;
      raw_h1_q     <= '0;
      raw_h2_q     <= '0;
      filt_h1_q    <= '0;
      filt_h2_q    <= '0;
    end else begin
      if (cmd_i.sample) begin
        prev_lines_q <= {line_a_q, line_b_q};
        case (code) inside
          CODE_UP_0, CODE_UP_1, CODE_UP_2, CODE_UP_3: count_q <= count_q + CB'(1);
          CODE_DN_0, CODE_DN_1, CODE_DN_2, CODE_DN_3: count_q <= count_q - CB'(1);
          default: ;
        endcase
      end
      if (cmd_i.rate_chk) begin
        if (scale_zero) begin
          raw_now_q <= '0;
        end else if (sat) begin
          raw_now_q <= neg_q ? qvf_pkg::RATE_MIN : qvf_pkg::RATE_MAX;
        end
      end
      if (cmd_i.rate_sign) begin
        raw_now_q <= neg_q ? -quo_ext : quo_ext;
      end
      if (cmd_i.filt_done) begin
        filt_h1_q <= filt_y;
        filt_h2_q <= filt_h1_q;
        raw_h1_q  <= raw_now_q;
        raw_h2_q  <= raw_h1_q;
        clast_q   <= count_q;
        tlast_q   <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      line_a_q <= in_line_a_i;
      line_b_q <= in_line_b_i;
      now_q    <= in_now_ms_i;
    end
    if (cmd_i.prep) begin
      dt_q  <= dt_d;
      dm_q  <= cnt_mag(diff);
      neg_q <= diff[CB-1];
    end
    if (cmd_i.rate_mul) begin
      p_q   <= qvf_pkg::PROD_W'(dm_q[qvf_pkg::MAG_W-1:0]) *
               qvf_pkg::PROD_W'(cfg_i.rate_scale);
      big_q <= (dm_q >> qvf_pkg::MAG_W) != '0;
    end
    if (cmd_i.rate_chk) begin
      // quotient fits in QUO_W bits here, so the top part is below dt
      rem_q <= qvf_pkg::TIME_W'(p_q >> qvf_pkg::SAT_SHIFT);
      dq_q  <= {p_q[qvf_pkg::SAT_SHIFT-1:0], {qvf_pkg::RATE_FRAC{1'b0}}};
    end
    if (cmd_i.div_step) begin
      rem_q <= fits ? trial_sub[qvf_pkg::TIME_W-1:0] : trial[qvf_pkg::TIME_W-1:0];
      dq_q  <= {dq_q[qvf_pkg::QUO_W-2:0], fits};
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + qvf_pkg::ACC_W'(prod_q);
    end
    if (cmd_i.out_load) begin
      out_pos_q  <= qvf_pkg::POS_W'($signed(count_q));
      out_raw_q  <= raw_now_q;
      out_filt_q <= filt_h1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register can take a new result when empty or being read this cycle
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o          = out_valid_q;
  assign out_position_count_o = out_pos_q;
  assign out_raw_rate_o       = out_raw_q;
  assign out_filtered_rate_o  = out_filt_q;

endmodule

FILE: rtl/quadrature_velocity_filter.sv
// a line sample updates the position count; a velocity update holds the rate,
// saturates it or runs the 31-step divide
// the block takes one item at a time, through the serial restoring divider and the
// shared 24x32 filter multiplier; a new item waits until the last one is done
// a finished result waits in the output register while the next item is taken
// reset (rst_ni low, async): counts, histories and rate cleared, coefficients to defaults
module quadrature_velocity_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  qvf_in_if.sink                          in_i,
  qvf_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qvf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [qvf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [qvf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  qvf_pkg::cfg_t     cfg;
  qvf_pkg::cmd_t     cmd;
  qvf_pkg::status_t  sts;

  qvf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qvf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_update_i (in_i.operation),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  qvf_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .cmd_i                (cmd),
    .in_line_a_i          (in_i.line_a),
    .in_line_b_i          (in_i.line_b),
    .in_now_ms_i          (in_i.now_ms),
    .out_ready_i          (out_o.ready),
    .sts_o                (sts),
    .out_valid_o          (out_o.valid),
    .out_position_count_o (out_o.position_count),
    .out_raw_rate_o       (out_o.raw_rate),
    .out_filtered_rate_o  (out_o.filtered_rate)
  );

endmodule
